[sv/ecrl_pkg.sv]
// Shared types and constants of the error counter with ring log.
`default_nettype none

package ecrl_pkg;

   // Field widths fixed by the request and result formats.
   localparam int STAMP_W    = 32;
   localparam int CODE_W     = 6;
   localparam int TASK_W     = 8;
   localparam int INDEX_W    = 8;
   localparam int COUNT_W    = 32;
   localparam int NEST_W     = 16;
   localparam int FILL_OUT_W = 5;
   localparam int MASK_W     = 64;

   // Top of the expect nesting depth.
   localparam logic [NEST_W-1:0] NEST_MAX = 16'hFFFF;

   // Operation codes of a request.
   typedef enum logic [1:0] {
      OP_REPORT       = 2'd0,
      OP_EXPECT_BEGIN = 2'd1,
      OP_EXPECT_END   = 2'd2,
      OP_READ         = 2'd3
   } op_type;

   // A classified request as it travels from the front to the back.
   typedef struct packed {
      op_type              op;
      logic [CODE_W-1:0]   code;
      logic [STAMP_W-1:0]  stamp;
      logic [TASK_W-1:0]   task_id;
      logic [INDEX_W-1:0]  read_index;
      logic                severity;
   } cmd_type;

   // One entry of the ring log.
   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [CODE_W-1:0]   code;
      logic [TASK_W-1:0]   task_id;
      logic                severity;
   } entry_type;

endpackage

`default_nettype wire

[sv/ecrl_if.sv]
// Request and result channel interfaces of the error counter with ring log.
`default_nettype none

interface ecrl_req_if;
   import ecrl_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [CODE_W-1:0]   error_code;
   logic [STAMP_W-1:0]  timestamp;
   logic [TASK_W-1:0]   task_id;
   logic [INDEX_W-1:0]  read_index;

   modport source (output valid, operation, error_code, timestamp, task_id, read_index,
                   input ready);
   modport sink (input valid, operation, error_code, timestamp, task_id, read_index,
                 output ready);
endinterface

interface ecrl_rsp_if;
   import ecrl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  entry_valid;
   logic [STAMP_W-1:0]    entry_timestamp;
   logic [CODE_W-1:0]     entry_code;
   logic [TASK_W-1:0]     entry_task;
   logic                  entry_severity;
   logic [COUNT_W-1:0]    total_errors;
   logic [COUNT_W-1:0]    expected_errors;
   logic [COUNT_W-1:0]    unexpected_errors;
   logic [CODE_W-1:0]     last_code;
   logic [FILL_OUT_W-1:0] log_fill;
   logic [COUNT_W-1:0]    log_writes;

   modport source (output valid, entry_valid, entry_timestamp, entry_code, entry_task,
                   entry_severity, total_errors, expected_errors, unexpected_errors,
                   last_code, log_fill, log_writes,
                   input ready);
   modport sink (input valid, entry_valid, entry_timestamp, entry_code, entry_task,
                 entry_severity, total_errors, expected_errors, unexpected_errors,
                 last_code, log_fill, log_writes,
                 output ready);
endinterface

`default_nettype wire

[sv/error_counter_ring_log.sv]
// Top level of the error counter with a newest-first ring log.
// A request accepted at the input is held in a command queue slot register, then executed into
//    the result register and the log read register, from which its result is shown.
// Throughput: one request per cycle when the result side is ready, set by the single
//    execute stage and the one memory port pair of the log.
// Reset (synchronous, active high) clears all counters, pointers, the fill count,
//    the nesting depth and the critical code mask; the log memory is not cleared.
`default_nettype none

module error_counter_ring_log #(
   parameter int LOG_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   ecrl_req_if.sink                    req_chan,
   ecrl_rsp_if.source                  rsp_chan,
   input  logic                        csr_write_en,
   input  logic [ecrl_pkg::MASK_W-1:0] csr_write_data
);
   import ecrl_pkg::*;

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   // Accept and classify requests.
   ecrl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_cmd       (push_cmd)
   );

   // Decouple the front from the back.
   ecrl_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Execute requests and produce results.
   ecrl_back #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

[sv/ecrl_front.sv]
// Front end: accepts requests, holds the critical code mask and classifies each request.
`default_nettype none

module ecrl_front (
   input  logic                        clock,
   input  logic                        reset,
   ecrl_req_if.sink                    req_chan,
   input  logic                        csr_write_en,
   input  logic [ecrl_pkg::MASK_W-1:0] csr_write_data,
   output logic                        push_valid,
   input  logic                        push_ready,
   output ecrl_pkg::cmd_type           push_cmd
);
   import ecrl_pkg::*;

   logic [MASK_W-1:0] mask_ff;

   // The critical code mask is written whenever the write enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_write_en) begin
         mask_ff <= csr_write_data;
      end
   end

   // A request passes into the queue whenever the queue has room.
   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

   // Classify the request and look up its severity in the mask.
   always_comb begin
      push_cmd.op         = op_type'(req_chan.operation);
      push_cmd.code       = req_chan.error_code;
      push_cmd.stamp      = req_chan.timestamp;
      push_cmd.task_id    = req_chan.task_id;
      push_cmd.read_index = req_chan.read_index;
      push_cmd.severity   = mask_ff[req_chan.error_code];
   end

endmodule

`default_nettype wire

[sv/ecrl_cmd_queue.sv]
// Two-entry queue of classified requests between the front and the back.
`default_nettype none

module ecrl_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ecrl_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ecrl_pkg::cmd_type pop_cmd
);
   import ecrl_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[sv/ecrl_back.sv]
// Back end: executes requests against the counters and the ring log memory.
`default_nettype none

module ecrl_back #(
   parameter int LOG_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  ecrl_pkg::cmd_type pop_cmd,
   ecrl_rsp_if.source        rsp_chan
);
   import ecrl_pkg::*;

   localparam int PTR_W  = $clog2(LOG_DEPTH);
   localparam int FILL_W = $clog2(LOG_DEPTH + 1);
   localparam int CMP_W  = (FILL_W > INDEX_W) ? FILL_W : INDEX_W;
   localparam int ADDR_W = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 2;

   entry_type           log_mem [LOG_DEPTH];
   entry_type           rd_data_ff;
   entry_type           wr_entry;

   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0]  writes_ff, writes_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  expected_ff, expected_in;
   logic [CODE_W-1:0]   last_ff, last_in;
   logic [NEST_W-1:0]   nest_ff, nest_in;
   logic                out_valid_ff;
   logic                hit_ff;

   logic                issue;
   logic                mem_wr;
   logic                mem_rd;
   logic                hit;
   logic [ADDR_W-1:0]   back_dist;
   logic [ADDR_W-1:0]   rd_pos;
   logic [PTR_W-1:0]    rd_addr;

   // A request is executed when the result register is free or being emptied.
   assign pop_ready = !out_valid_ff || rsp_chan.ready;
   assign issue     = pop_valid && pop_ready;

   // A read hits when its index is below the fill count.
   assign hit = (CMP_W'(pop_cmd.read_index) < CMP_W'(fill_ff));

   // Newest-first address: one step back from the write pointer, then index more.
   always_comb begin
      back_dist = ADDR_W'(wp_ff) + ADDR_W'(LOG_DEPTH) - ADDR_W'(1)
                  - ADDR_W'(pop_cmd.read_index);
      if (back_dist >= ADDR_W'(LOG_DEPTH)) begin
         rd_pos = back_dist - ADDR_W'(LOG_DEPTH);
      end else begin
         rd_pos = back_dist;
      end
      rd_addr = rd_pos[PTR_W-1:0];
   end

   assign wr_entry = '{stamp: pop_cmd.stamp, code: pop_cmd.code,
                       task_id: pop_cmd.task_id, severity: pop_cmd.severity};

   // Next state of the counters for the executed request.
   always_comb begin
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      writes_in   = writes_ff;
      total_in    = total_ff;
      expected_in = expected_ff;
      last_in     = last_ff;
      nest_in     = nest_ff;
      mem_wr      = 1'b0;
      mem_rd      = 1'b0;
      if (issue) begin
         unique case (pop_cmd.op)
            OP_REPORT: begin
               mem_wr    = 1'b1;
               total_in  = total_ff + 1'b1;
               writes_in = writes_ff + 1'b1;
               last_in   = pop_cmd.code;
               if (nest_ff != '0) begin
                  expected_in = expected_ff + 1'b1;
               end
               if (wp_ff == PTR_W'(LOG_DEPTH - 1)) begin
                  wp_in = '0;
               end else begin
                  wp_in = wp_ff + 1'b1;
               end
               if (fill_ff != FILL_W'(LOG_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
            OP_EXPECT_BEGIN: begin
               if (nest_ff != NEST_MAX) begin
                  nest_in = nest_ff + 1'b1;
               end
            end
            OP_EXPECT_END: begin
               if (nest_ff != '0) begin
                  nest_in = nest_ff - 1'b1;
               end
            end
            OP_READ: begin
               mem_rd = 1'b1;
            end
         endcase
      end
   end

   // Counter state and result control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         fill_ff      <= '0;
         writes_ff    <= '0;
         total_ff     <= '0;
         expected_ff  <= '0;
         last_ff      <= '0;
         nest_ff      <= '0;
         out_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         writes_ff   <= writes_in;
         total_ff    <= total_in;
         expected_ff <= expected_in;
         last_ff     <= last_in;
         nest_ff     <= nest_in;
         if (issue) begin
            out_valid_ff <= 1'b1;
            hit_ff       <= (pop_cmd.op == OP_READ) && hit;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
            hit_ff       <= 1'b0;
         end
      end
   end

   // Ring log memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         log_mem[wp_ff] <= wr_entry;
      end
      if (mem_rd) begin
         rd_data_ff <= log_mem[rd_addr];
      end
   end

   // The counters only change on issue, so they always match the held result.
   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.entry_valid       = hit_ff;
   assign rsp_chan.entry_timestamp   = hit_ff ? rd_data_ff.stamp : '0;
   assign rsp_chan.entry_code        = hit_ff ? rd_data_ff.code : '0;
   assign rsp_chan.entry_task        = hit_ff ? rd_data_ff.task_id : '0;
   assign rsp_chan.entry_severity    = hit_ff && rd_data_ff.severity;
   assign rsp_chan.total_errors      = total_ff;
   assign rsp_chan.expected_errors   = expected_ff;
   assign rsp_chan.unexpected_errors = total_ff - expected_ff;
   assign rsp_chan.last_code         = last_ff;
   assign rsp_chan.log_fill          = FILL_OUT_W'(fill_ff);
   assign rsp_chan.log_writes        = writes_ff;

   // Checks on the execution logic.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(LOG_DEPTH))
      else $error("fill count above log depth");

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PTR_W'(LOG_DEPTH - 1))
      else $error("write pointer out of range");

   a_report_counts: assert property (@(posedge clock) disable iff (reset)
      issue && (pop_cmd.op == OP_REPORT)
      |=> (total_ff == $past(total_ff) + 1'b1) && (writes_ff == $past(writes_ff) + 1'b1))
      else $error("report did not advance the counters");

   a_expected_only_on_report: assert property (@(posedge clock) disable iff (reset)
      !(issue && (pop_cmd.op == OP_REPORT)) |=> $stable(expected_ff) && $stable(total_ff))
      else $error("error counters changed without a report");

   a_hit_with_result: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> out_valid_ff)
      else $error("log hit flag set without a pending result");

endmodule

`default_nettype wire
